>>> src/box_q_intersection_macros.svh
// Assertion macros for the box q-intersection block.
`ifndef BOX_Q_INTERSECTION_MACROS_SVH
`define BOX_Q_INTERSECTION_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define BQI_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every edge, reset included.
`define BQI_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BQI_ASSERT(label, prop)
`define BQI_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> src/bqi_pkg.sv
package bqi_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_LATCH,
        S_SCAN,
        S_EVAL,
        S_UPD,
        S_DIMEND,
        S_EMIT
    } state_t;

    localparam logic CFG_MIN_OVERLAP = 1'b0;
    localparam logic CFG_DIM_COUNT   = 1'b1;

    localparam int RES_N = 16;

    typedef struct packed {
        logic       wr_en;
        logic       wr_drop;
        logic       cand_latch;
        logic       scan_rd;
        logic       eval;
        logic       clear_best;
        logic       store_res;
        logic       emit;
        logic       fail;
        logic       ovf;
        logic       last;
        logic [6:0] q;
        logic [3:0] dim;
    } cmd_t;

    typedef struct packed {
        logic reversed;
        logic cand_drop;
        logic found_l;
        logic found_u;
    } status_t;

endpackage

>>> src/bqi_ram.sv
module bqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/bqi_datapath.sv
module bqi_datapath #(
    parameter int MAX_BOXES = 64,
    parameter int MAX_DIMS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bqi_pkg::cmd_t         cmd,
    output bqi_pkg::status_t      status,
    input  logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] wr_box,
    input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0]   wr_dim,
    input  logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] rd_box,
    input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0]   rd_dim,
    input  logic signed [31:0]    lower_end,
    input  logic signed [31:0]    upper_end,
    output logic                  done,
    output logic [3:0]            dim_index,
    output logic signed [31:0]    res_lower,
    output logic signed [31:0]    res_upper,
    output logic                  res_empty,
    output logic                  dropped_boxes,
    output logic                  last_dim
);

    localparam int BW    = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
    localparam int DW    = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH = 2 ** (BW + DW);
    localparam int ACW   = $clog2(MAX_BOXES + 1) + 1;
    localparam int CMPW  = ACW > 8 ? ACW : 8;

    logic [31:0] lo_q;
    logic [31:0] hi_q;
    logic        drop_q;
    logic signed [31:0] rd_lo;
    logic signed [31:0] rd_hi;

    logic signed [31:0]    cand_lo_reg;
    logic signed [31:0]    cand_hi_reg;
    logic signed [ACW-1:0] acc_l_reg, acc_l_next;
    logic signed [ACW-1:0] acc_u_reg, acc_u_next;
    logic                  scan_vld_reg;
    logic signed [31:0]    best_l_reg;
    logic signed [31:0]    best_u_reg;
    logic                  found_l_reg;
    logic                  found_u_reg;
    logic signed [31:0]    res_lo_reg [bqi_pkg::RES_N];
    logic signed [31:0]    res_hi_reg [bqi_pkg::RES_N];

    logic                  done_reg;
    logic [3:0]            dim_index_reg;
    logic signed [31:0]    res_lower_reg;
    logic signed [31:0]    res_upper_reg;
    logic                  res_empty_reg;
    logic                  dropped_reg;
    logic                  last_reg;

    logic signed [CMPW-1:0] acc_l_x;
    logic signed [CMPW-1:0] acc_u_x;
    logic signed [CMPW-1:0] q_x;

    bqi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_lower_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr ({wr_box, wr_dim}),
        .wdata (lower_end),
        .raddr ({rd_box, rd_dim}),
        .rdata (lo_q)
    );

    bqi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_upper_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr ({wr_box, wr_dim}),
        .wdata (upper_end),
        .raddr ({rd_box, rd_dim}),
        .rdata (hi_q)
    );

    bqi_ram #(.WIDTH(1), .DEPTH(2 ** BW)) u_drop_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_box),
        .wdata (cmd.wr_drop),
        .raddr (rd_box),
        .rdata (drop_q)
    );

    assign rd_lo = $signed(lo_q);
    assign rd_hi = $signed(hi_q);

    assign status.reversed  = lower_end > upper_end;
    assign status.cand_drop = drop_q;
    assign status.found_l   = found_l_reg;
    assign status.found_u   = found_u_reg;

    // depth counts: lowers at or below / uppers strictly below the candidate lower,
    // mirrored for the candidate upper
    always_comb
    begin
        acc_l_next = acc_l_reg;
        acc_u_next = acc_u_reg;
        if (cmd.cand_latch)
        begin
            acc_l_next = '0;
            acc_u_next = '0;
        end
        else if (scan_vld_reg && !drop_q)
        begin
            if (rd_lo <= cand_lo_reg)
            begin
                acc_l_next = acc_l_next + ACW'(1);
            end
            if (rd_hi < cand_lo_reg)
            begin
                acc_l_next = acc_l_next - ACW'(1);
            end
            if (rd_hi >= cand_hi_reg)
            begin
                acc_u_next = acc_u_next + ACW'(1);
            end
            if (rd_lo > cand_hi_reg)
            begin
                acc_u_next = acc_u_next - ACW'(1);
            end
        end
    end

    assign acc_l_x = CMPW'(acc_l_reg);
    assign acc_u_x = CMPW'(acc_u_reg);
    assign q_x     = $signed(CMPW'(cmd.q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_vld_reg <= 1'b0;
            found_l_reg  <= 1'b0;
            found_u_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.scan_rd;
            done_reg     <= cmd.emit;
            if (cmd.clear_best)
            begin
                found_l_reg <= 1'b0;
                found_u_reg <= 1'b0;
            end
            else if (cmd.eval)
            begin
                if (acc_l_x >= q_x && (!found_l_reg || cand_lo_reg < best_l_reg))
                begin
                    found_l_reg <= 1'b1;
                end
                if (acc_u_x >= q_x && (!found_u_reg || cand_hi_reg > best_u_reg))
                begin
                    found_u_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_l_reg <= acc_l_next;
        acc_u_reg <= acc_u_next;
        if (cmd.cand_latch)
        begin
            cand_lo_reg <= rd_lo;
            cand_hi_reg <= rd_hi;
        end
        if (cmd.eval)
        begin
            if (acc_l_x >= q_x && (!found_l_reg || cand_lo_reg < best_l_reg))
            begin
                best_l_reg <= cand_lo_reg;
            end
            if (acc_u_x >= q_x && (!found_u_reg || cand_hi_reg > best_u_reg))
            begin
                best_u_reg <= cand_hi_reg;
            end
        end
        if (cmd.store_res)
        begin
            res_lo_reg[cmd.dim] <= best_l_reg;
            res_hi_reg[cmd.dim] <= best_u_reg;
        end
        if (cmd.emit)
        begin
            dim_index_reg <= cmd.dim;
            res_lower_reg <= cmd.fail ? 32'sd0 : res_lo_reg[cmd.dim];
            res_upper_reg <= cmd.fail ? 32'sd0 : res_hi_reg[cmd.dim];
            res_empty_reg <= cmd.fail;
            dropped_reg   <= cmd.ovf;
            last_reg      <= cmd.last;
        end
    end

    assign done          = done_reg;
    assign dim_index     = dim_index_reg;
    assign res_lower     = res_lower_reg;
    assign res_upper     = res_upper_reg;
    assign res_empty     = res_empty_reg;
    assign dropped_boxes = dropped_reg;
    assign last_dim      = last_reg;

endmodule

>>> src/bqi_ctrl.sv
`include "box_q_intersection_macros.svh"

module bqi_ctrl #(
    parameter int MAX_BOXES = 64,
    parameter int MAX_DIMS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  comp_empty,
    input  logic                  final_item,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [6:0]            cfg_data,
    input  bqi_pkg::status_t      status,
    output bqi_pkg::cmd_t         cmd,
    output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] wr_box,
    output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0]   wr_dim,
    output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] rd_box,
    output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0]   rd_dim
);

    localparam int BW      = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
    localparam int DW      = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
    localparam int BCW     = $clog2(MAX_BOXES + 1);
    localparam int DIM_CAP = MAX_DIMS < bqi_pkg::RES_N ? MAX_DIMS : bqi_pkg::RES_N;

    bqi_pkg::state_t state_reg, state_next;

    logic [6:0]     min_overlap_reg;
    logic [4:0]     dim_count_reg;
    logic [4:0]     item_cnt_reg, item_cnt_next;
    logic [BCW-1:0] box_cnt_reg, box_cnt_next;
    logic           ovf_reg, ovf_next;
    logic           cur_drop_reg, cur_drop_next;
    logic           fail_reg, fail_next;
    logic [BW-1:0]  j_reg, j_next;
    logic [BW-1:0]  k_reg, k_next;
    logic [3:0]     d_reg, d_next;

    logic [4:0]     dc;
    logic [4:0]     ic1;
    logic [4:0]     ic2;
    logic [BCW-1:0] bc1;
    logic [BCW-1:0] bc2;
    logic           emp;
    logic           drop_val;
    logic           j_last;
    logic           k_last;
    logic           d_last;

    always_comb
    begin
        dc = dim_count_reg;
        if (dc == 5'd0)
        begin
            dc = 5'd1;
        end
        if (dc > 5'(DIM_CAP))
        begin
            dc = 5'(DIM_CAP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_overlap_reg <= 7'd1;
            dim_count_reg   <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bqi_pkg::CFG_MIN_OVERLAP: min_overlap_reg <= cfg_data;
                bqi_pkg::CFG_DIM_COUNT:   dim_count_reg   <= cfg_data[4:0];
                default:                  ;
            endcase
        end
    end

    // load path: close a box first if dim_count was lowered, store, then close on fill
    always_comb
    begin
        emp = comp_empty | status.reversed;
        ic1 = item_cnt_reg;
        bc1 = box_cnt_reg;
        if (ic1 >= dc)
        begin
            ic1 = 5'd0;
            if (bc1 < BCW'(MAX_BOXES))
            begin
                bc1 = bc1 + BCW'(1);
            end
        end
        drop_val = (ic1 == 5'd0) ? emp : (cur_drop_reg | emp);
        ic2 = ic1 + 5'd1;
        bc2 = bc1;
        if (ic2 >= dc)
        begin
            ic2 = 5'd0;
            if (bc2 < BCW'(MAX_BOXES))
            begin
                bc2 = bc2 + BCW'(1);
            end
        end
    end

    assign j_last = (BCW'(j_reg) + BCW'(1)) >= box_cnt_reg;
    assign k_last = (BCW'(k_reg) + BCW'(1)) >= box_cnt_reg;
    assign d_last = ({1'b0, d_reg} + 5'd1) == dc;

    assign wr_box = BW'(bc1);
    assign wr_dim = DW'(ic1);
    assign rd_dim = DW'(d_reg);

    always_comb
    begin
        state_next    = state_reg;
        item_cnt_next = item_cnt_reg;
        box_cnt_next  = box_cnt_reg;
        ovf_next      = ovf_reg;
        cur_drop_next = cur_drop_reg;
        fail_next     = fail_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        d_next        = d_reg;
        cmd           = '0;
        cmd.q         = (min_overlap_reg == 7'd0) ? 7'd1 : min_overlap_reg;
        cmd.dim       = d_reg;
        cmd.fail      = fail_reg;
        cmd.ovf       = ovf_reg;
        cmd.last      = d_last;
        cmd.wr_drop   = drop_val;
        rd_box        = j_reg;
        busy          = 1'b1;

        unique case (state_reg)
            bqi_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (bc1 < BCW'(MAX_BOXES))
                    begin
                        cmd.wr_en     = 1'b1;
                        cur_drop_next = drop_val;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    item_cnt_next = ic2;
                    box_cnt_next  = bc2;
                    if (final_item)
                    begin
                        item_cnt_next  = 5'd0;
                        cmd.clear_best = 1'b1;
                        d_next         = 4'd0;
                        j_next         = '0;
                        if (bc2 == '0)
                        begin
                            fail_next  = 1'b1;
                            state_next = bqi_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = bqi_pkg::S_CAND;
                        end
                    end
                end
            end
            bqi_pkg::S_CAND:
            begin
                state_next = bqi_pkg::S_LATCH;
            end
            bqi_pkg::S_LATCH:
            begin
                cmd.cand_latch = 1'b1;
                if (status.cand_drop)
                begin
                    if (j_last)
                    begin
                        state_next = bqi_pkg::S_DIMEND;
                    end
                    else
                    begin
                        j_next     = j_reg + BW'(1);
                        state_next = bqi_pkg::S_CAND;
                    end
                end
                else
                begin
                    k_next     = '0;
                    state_next = bqi_pkg::S_SCAN;
                end
            end
            bqi_pkg::S_SCAN:
            begin
                rd_box      = k_reg;
                cmd.scan_rd = 1'b1;
                if (k_last)
                begin
                    state_next = bqi_pkg::S_EVAL;
                end
                else
                begin
                    k_next = k_reg + BW'(1);
                end
            end
            bqi_pkg::S_EVAL:
            begin
                state_next = bqi_pkg::S_UPD;
            end
            bqi_pkg::S_UPD:
            begin
                cmd.eval = 1'b1;
                if (j_last)
                begin
                    state_next = bqi_pkg::S_DIMEND;
                end
                else
                begin
                    j_next     = j_reg + BW'(1);
                    state_next = bqi_pkg::S_CAND;
                end
            end
            bqi_pkg::S_DIMEND:
            begin
                if (!(status.found_l && status.found_u))
                begin
                    fail_next  = 1'b1;
                    d_next     = 4'd0;
                    state_next = bqi_pkg::S_EMIT;
                end
                else
                begin
                    cmd.store_res = 1'b1;
                    if (d_last)
                    begin
                        d_next     = 4'd0;
                        state_next = bqi_pkg::S_EMIT;
                    end
                    else
                    begin
                        d_next         = d_reg + 4'd1;
                        j_next         = '0;
                        cmd.clear_best = 1'b1;
                        state_next     = bqi_pkg::S_CAND;
                    end
                end
            end
            bqi_pkg::S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (d_last)
                begin
                    box_cnt_next = '0;
                    ovf_next     = 1'b0;
                    fail_next    = 1'b0;
                    d_next       = 4'd0;
                    state_next   = bqi_pkg::S_IDLE;
                end
                else
                begin
                    d_next = d_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = bqi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bqi_pkg::S_IDLE;
            item_cnt_reg <= '0;
            box_cnt_reg  <= '0;
            ovf_reg      <= 1'b0;
            cur_drop_reg <= 1'b0;
            fail_reg     <= 1'b0;
            j_reg        <= '0;
            k_reg        <= '0;
            d_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            item_cnt_reg <= item_cnt_next;
            box_cnt_reg  <= box_cnt_next;
            ovf_reg      <= ovf_next;
            cur_drop_reg <= cur_drop_next;
            fail_reg     <= fail_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            d_reg        <= d_next;
        end
    end

    `BQI_ASSERT(a_final_starts_work, (state_reg == bqi_pkg::S_IDLE && start && final_item) |=> busy)
    `BQI_ASSERT(a_emit_in_range, (state_reg == bqi_pkg::S_EMIT) |-> ({1'b0, d_reg} < dc))
    `BQI_ASSERT(a_scan_in_range, (state_reg == bqi_pkg::S_SCAN) |-> (BCW'(k_reg) < box_cnt_reg))
    `BQI_ASSERT_ALWAYS(a_box_cap, box_cnt_reg <= BCW'(MAX_BOXES))

endmodule

>>> src/box_q_intersection.sv
// q-relaxed intersection of axis-aligned boxes, signed Q16.16 coordinates.
// Request channel: one component per request, accepted at a clock edge with
// start high and busy low; boxes arrive box after box, dim_count components each.
// Requests may follow back to back. A request with final_item set starts the
// computation; busy stays high until the last result has been issued.
// Configuration: cfg_we / cfg_index / cfg_data, written while idle.
// Computation: for every dimension and every stored box, one candidate read
// (states CAND, LATCH) and, for kept boxes, a scan over all N stored boxes
// (SCAN, then EVAL, UPD) through one read port of the endpoint memories;
// the computation stops at the first dimension with no result.
// Results: one per dimension, back to back, each marked by done for
// exactly one cycle; they are issued from the EMIT state once the last
// dimension is finished or one fails. The receiver cannot stall.
// Reset clears the load counters and sets min_overlap and dim_count to 1;
// the endpoint memories need no clearing pass.
module box_q_intersection #(
    parameter int MAX_BOXES = 64,
    parameter int MAX_DIMS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] lower_end,
    input  logic signed [31:0] upper_end,
    input  logic               comp_empty,
    input  logic               final_item,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    output logic               done,
    output logic [3:0]         dim_index,
    output logic signed [31:0] res_lower,
    output logic signed [31:0] res_upper,
    output logic               res_empty,
    output logic               dropped_boxes,
    output logic               last_dim
);

    localparam int BW = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
    localparam int DW = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;

    bqi_pkg::cmd_t    cmd;
    bqi_pkg::status_t status;
    logic [BW-1:0]    wr_box;
    logic [DW-1:0]    wr_dim;
    logic [BW-1:0]    rd_box;
    logic [DW-1:0]    rd_dim;

    bqi_ctrl #(.MAX_BOXES(MAX_BOXES), .MAX_DIMS(MAX_DIMS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .comp_empty (comp_empty),
        .final_item (final_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .cmd        (cmd),
        .wr_box     (wr_box),
        .wr_dim     (wr_dim),
        .rd_box     (rd_box),
        .rd_dim     (rd_dim)
    );

    bqi_datapath #(.MAX_BOXES(MAX_BOXES), .MAX_DIMS(MAX_DIMS)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .wr_box        (wr_box),
        .wr_dim        (wr_dim),
        .rd_box        (rd_box),
        .rd_dim        (rd_dim),
        .lower_end     (lower_end),
        .upper_end     (upper_end),
        .done          (done),
        .dim_index     (dim_index),
        .res_lower     (res_lower),
        .res_upper     (res_upper),
        .res_empty     (res_empty),
        .dropped_boxes (dropped_boxes),
        .last_dim      (last_dim)
    );

endmodule

>>> tb/tb_box_q_intersection.sv
module tb_box_q_intersection;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX = 64;
    localparam int NDIM = 16;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] POS_INF = 32'sh7FFF_FFFF;

    typedef struct {
        logic [3:0]         dim;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               emp;
        logic               drop;
        logic               last;
    } dim_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] lower_end = '0;
    logic signed [31:0] upper_end = '0;
    logic               comp_empty = 1'b0;
    logic               final_item = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = bqi_pkg::CFG_MIN_OVERLAP;
    logic [6:0]         cfg_data = '0;
    logic               done;
    logic [3:0]         dim_index;
    logic signed [31:0] res_lower;
    logic signed [31:0] res_upper;
    logic               res_empty;
    logic               dropped_boxes;
    logic               last_dim;

    box_q_intersection u_top (.*);

    // predictor state
    logic [6:0]         q_reg = 7'd1;
    logic [4:0]         dims_reg = 5'd1;
    logic signed [31:0] lo_mem[NBOX*NDIM];
    logic signed [31:0] hi_mem[NBOX*NDIM];
    bit                 box_void[NBOX];
    int                 item_cnt = 0;
    int                 box_cnt = 0;
    bit                 ovf = 0;

    dim_res_t pending_dims[$];
    int     idle_pct = 0;
    int     errors = 0;
    int     mismatches = 0;
    longint cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_dims();
        if (dims_reg == 0) return 1;
        if (dims_reg > NDIM) return NDIM;
        return dims_reg;
    endfunction

    function automatic void predict_component(logic signed [31:0] lo, logic signed [31:0] hi,
                                              logic emp_in, logic fin);
        int dce, qq, p, n, c, i, j, k, d;
        int valid[NBOX];
        logic signed [31:0] pv[2*NBOX];
        bit pu[2*NBOX];
        logic signed [31:0] kv;
        bit ku, all_empty, got_lo, got_hi, emp;
        logic signed [31:0] rl[NDIM];
        logic signed [31:0] ru[NDIM];
        dim_res_t r;
        dce = eff_dims();
        qq = (q_reg == 0) ? 1 : q_reg;
        emp = emp_in || (lo > hi);
        if (item_cnt >= dce) begin
            if (box_cnt < NBOX) box_cnt++;
            item_cnt = 0;
        end
        if (box_cnt < NBOX) begin
            lo_mem[box_cnt*NDIM + item_cnt] = lo;
            hi_mem[box_cnt*NDIM + item_cnt] = hi;
            box_void[box_cnt] = (item_cnt == 0) ? emp : (box_void[box_cnt] | emp);
        end else begin
            ovf = 1;
        end
        item_cnt++;
        if (item_cnt >= dce) begin
            if (box_cnt < NBOX) box_cnt++;
            item_cnt = 0;
        end
        if (!fin) return;
        item_cnt = 0;
        p = 0;
        for (i = 0; i < box_cnt && i < NBOX; i++)
            if (!box_void[i]) valid[p++] = i;
        all_empty = (p == 0);
        for (d = 0; d < dce && !all_empty; d++) begin
            n = 2 * p;
            for (k = 0; k < p; k++) begin
                pv[2*k] = lo_mem[valid[k]*NDIM + d];
                pu[2*k] = 0;
                pv[2*k+1] = hi_mem[valid[k]*NDIM + d];
                pu[2*k+1] = 1;
            end
            for (i = 1; i < n; i++) begin
                kv = pv[i];
                ku = pu[i];
                j = i;
                while (j > 0 && (kv < pv[j-1] || (kv == pv[j-1] && ku < pu[j-1]))) begin
                    pv[j] = pv[j-1];
                    pu[j] = pu[j-1];
                    j--;
                end
                pv[j] = kv;
                pu[j] = ku;
            end
            got_lo = 0;
            got_hi = 0;
            c = 0;
            for (k = 0; k < n; k++) begin
                c += pu[k] ? -1 : 1;
                if (c == qq) begin
                    rl[d] = pv[k];
                    got_lo = 1;
                    break;
                end
            end
            c = 0;
            for (k = n; k > 0; k--) begin
                c += pu[k-1] ? 1 : -1;
                if (c == qq) begin
                    ru[d] = pv[k-1];
                    got_hi = 1;
                    break;
                end
            end
            if (!got_lo || !got_hi) all_empty = 1;
        end
        for (d = 0; d < dce; d++) begin
            r.dim = d[3:0];
            r.lo = all_empty ? 32'sd0 : rl[d];
            r.hi = all_empty ? 32'sd0 : ru[d];
            r.emp = all_empty;
            r.drop = ovf;
            r.last = (d + 1 == dce);
            pending_dims.push_back(r);
        end
        box_cnt = 0;
        ovf = 0;
    endfunction

    // result checker
    always @(posedge clk) begin
        dim_res_t e;
        if (rst_n && done) begin
            if (pending_dims.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result dim=%0d lo=%h hi=%h", dim_index, res_lower,
                             res_upper);
            end else begin
                e = pending_dims.pop_front();
                if (dim_index !== e.dim || res_lower !== e.lo || res_upper !== e.hi ||
                    res_empty !== e.emp || dropped_boxes !== e.drop || last_dim !== e.last)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp dim=%0d lo=%h hi=%h emp=%b drop=%b last=%b / got dim=%0d lo=%h hi=%h emp=%b drop=%b last=%b",
                                 e.dim, e.lo, e.hi, e.emp, e.drop, e.last, dim_index,
                                 res_lower, res_upper, res_empty, dropped_boxes, last_dim);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_box_q_intersection: FAIL");
            $finish;
        end
    end

    task automatic send_component(logic signed [31:0] lo, logic signed [31:0] hi,
                                  logic emp, logic fin);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        lower_end <= lo;
        upper_end <= hi;
        comp_empty <= emp;
        final_item <= fin;
        do @(posedge clk); while (busy);
        predict_component(lo, hi, emp, fin);
    endtask

    // hold off until every pending result is out and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_dims.size() != 0 || busy) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [6:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bqi_pkg::CFG_MIN_OVERLAP) q_reg = val;
        else dims_reg = val[4:0];
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return NEG_INF;
            1: return POS_INF;
            2: return $urandom;
            default: return $signed($urandom_range(40)) - 20 <<< 16;
        endcase
    endfunction

    // one load: nb boxes of random content, optional partial box, final on last
    task automatic send_load(int nb, bit partial);
        int dce, total, i;
        logic signed [31:0] lo, hi;
        dce = eff_dims();
        total = nb * dce + (partial ? $urandom_range(dce > 1 ? dce - 1 : 1, 1) : 0);
        if (total == 0) total = 1;
        for (i = 0; i < total; i++) begin
            lo = rand_coord();
            if ($urandom_range(3) == 0) hi = rand_coord();
            else hi = (lo > POS_INF - 32'sh0010_0000) ? POS_INF
                                                     : lo + $signed($urandom_range(20) <<< 16);
            send_component(lo, hi, $urandom_range(11) == 0, i == total - 1);
        end
    endtask

    task automatic test_directed();
        send_component(NEG_INF, POS_INF, 1'b0, 1'b1);
        send_component(32'sd5, 32'sd9, 1'b1, 1'b1);
        send_component(32'sd9, 32'sd5, 1'b0, 1'b1);
        write_cfg(bqi_pkg::CFG_MIN_OVERLAP, 7'd0);
        send_component(-32'sd7, 32'sd3, 1'b0, 1'b0);
        send_component(32'sd1, 32'sd8, 1'b0, 1'b1);
        write_cfg(bqi_pkg::CFG_MIN_OVERLAP, 7'd2);
        write_cfg(bqi_pkg::CFG_DIM_COUNT, 7'd3);
        // touching intervals and a partial box at the end
        send_component(32'sd0, 32'sd10, 1'b0, 1'b0);
        send_component(NEG_INF, 32'sd4, 1'b0, 1'b0);
        send_component(32'sd2, POS_INF, 1'b0, 1'b0);
        send_component(32'sd10, 32'sd20, 1'b0, 1'b0);
        send_component(32'sd4, 32'sd6, 1'b0, 1'b0);
        send_component(-32'sd5, 32'sd2, 1'b0, 1'b0);
        send_component(32'sd99, 32'sd100, 1'b0, 1'b1);
        write_cfg(bqi_pkg::CFG_MIN_OVERLAP, 7'd127);
        send_component(32'sd1, 32'sd2, 1'b0, 1'b0);
        send_component(32'sd1, 32'sd2, 1'b0, 1'b0);
        send_component(32'sd1, 32'sd2, 1'b0, 1'b1);
        write_cfg(bqi_pkg::CFG_MIN_OVERLAP, 7'd1);
        write_cfg(bqi_pkg::CFG_DIM_COUNT, 7'd0);
        send_component(-32'sd1, 32'sd1, 1'b0, 1'b1);
        write_cfg(bqi_pkg::CFG_DIM_COUNT, 7'd31);
        send_load(2, 0);
    endtask

    task automatic test_capacity();
        int i;
        write_cfg(bqi_pkg::CFG_DIM_COUNT, 7'd1);
        write_cfg(bqi_pkg::CFG_MIN_OVERLAP, 7'd64);
        for (i = 0; i < NBOX + 2; i++)
            send_component(-$signed($urandom_range(1000)), $signed($urandom_range(1000)),
                           1'b0, i == NBOX + 1);
        write_cfg(bqi_pkg::CFG_MIN_OVERLAP, 7'd3);
        write_cfg(bqi_pkg::CFG_DIM_COUNT, 7'd16);
        send_load(3, 0);
        send_load(4, 1);
    endtask

    task automatic test_random(int pct, int budget);
        int sent;
        idle_pct = pct;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(2) == 0) begin
                write_cfg(bqi_pkg::CFG_MIN_OVERLAP,
                          7'($urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(4)));
                write_cfg(bqi_pkg::CFG_DIM_COUNT,
                          7'($urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(4)));
            end
            sent += box_cnt;
            send_load($urandom_range(8), $urandom_range(7) == 0);
            sent += eff_dims() * 4 + 1;
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random(29, 55);
        test_random(84, 55);
        test_random(0, 55);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_dims.size() == 0)
            $display("tb_box_q_intersection: PASS");
        else
            $display("tb_box_q_intersection: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/bqi_pkg.sv
src/bqi_ram.sv
src/bqi_datapath.sv
src/bqi_ctrl.sv
src/box_q_intersection.sv
tb/tb_box_q_intersection.sv
